/* rtl/core/bsc_pkg.sv */
// shared types, codes and constants of the beacon security classifier
// no dependencies; every other file of the block refers to it by scoped names
`default_nettype none

package bsc_pkg;

  // frame layout
  localparam int MAX_FRAME_BYTES_DEF = 4095;
  localparam int CAP_LO_BASE         = 34;
  localparam int ORDER_EXTRA         = 4;
  localparam int ELEM_OFFSET         = 2;

  // byte queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // bit masks in header bytes
  localparam logic [7:0] ORDER_MASK   = 8'h80;
  localparam logic [7:0] PRIVACY_MASK = 8'h10;

  // element ids and suite fields
  localparam logic [7:0] ID_RSN       = 8'd48;
  localparam logic [7:0] ID_VENDOR    = 8'd221;
  localparam logic [7:0] RSN_OUI_1    = 8'h0F;
  localparam logic [7:0] RSN_OUI_2    = 8'hAC;
  localparam logic [7:0] WPA_OUI_1    = 8'h50;
  localparam logic [7:0] WPA_OUI_2    = 8'hF2;
  localparam logic [7:0] RSN_COUNT_AT = 8'd6;
  localparam logic [7:0] WPA_COUNT_AT = 8'd10;
  localparam logic [7:0] WPA_HDR_LEN  = 8'd4;

  // akm suite types
  localparam logic [7:0] AKM_8021X        = 8'h01;
  localparam logic [7:0] AKM_PSK          = 8'h02;
  localparam logic [7:0] AKM_8021X_SHA256 = 8'h05;
  localparam logic [7:0] AKM_SAE          = 8'h08;

  // security classes
  typedef logic [3:0] cls_t;
  localparam cls_t CLS_OPEN      = 4'd0;
  localparam cls_t CLS_WEP       = 4'd1;
  localparam cls_t CLS_WPA_PSK   = 4'd2;
  localparam cls_t CLS_WPA_ENT   = 4'd3;
  localparam cls_t CLS_WPA2_PSK  = 4'd4;
  localparam cls_t CLS_WPA2_ENT  = 4'd5;
  localparam cls_t CLS_WPA3_SAE  = 4'd6;
  localparam cls_t CLS_WPA3_ENT  = 4'd7;
  localparam cls_t CLS_PSK_TRANS = 4'd8;
  localparam cls_t CLS_ENT_TRANS = 4'd9;
  localparam cls_t CLS_UNKNOWN   = 4'd10;

  // role of one byte as seen by the front
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CAP  = 2'd1,
    KIND_ELEM = 2'd2
  } kind_t;

  // element parser phase
  typedef enum logic [6:0] {
    PH_ID     = 7'b0000001,
    PH_LEN    = 7'b0000010,
    PH_SKIP   = 7'b0000100,
    PH_FIX    = 7'b0001000,
    PH_PAIR   = 7'b0010000,
    PH_AKMCNT = 7'b0100000,
    PH_AKM    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
    logic       short_frame;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // wpa vendor element header 00-50-F2-01
  function automatic logic [7:0] wpa_hdr_byte(input logic [1:0] i);
    logic [7:0] v;
    case (i)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h50;
      2'd2:    v = 8'hF2;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bsc_front.sv */
// front of the classifier: takes frame bytes, tracks position and order bit,
// tags each byte with its role; uses bsc_pkg
`default_nettype none

module bsc_front #(
  parameter int MAX_FRAME_BYTES = bsc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  input  wire bsc_pkg::q_stat_t q_stat,
  output logic                 push,
  output bsc_pkg::entry_t      push_entry
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX  = PW'(MAX_FRAME_BYTES);
  localparam logic [PW-1:0] CAP_LO_N = PW'(bsc_pkg::CAP_LO_BASE);
  localparam logic [PW-1:0] CAP_LO_O = PW'(bsc_pkg::CAP_LO_BASE + bsc_pkg::ORDER_EXTRA);
  localparam logic [PW-1:0] ELEM_OFS = PW'(bsc_pkg::ELEM_OFFSET);

  logic [PW-1:0] pos;
  logic          order_seen;
  logic          order_next;
  logic [PW-1:0] cap_lo;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign order_next = order_seen ||
                      ((pos == PW'(1)) && ((data_byte & bsc_pkg::ORDER_MASK) != 8'h00));
  assign cap_lo     = order_next ? CAP_LO_O : CAP_LO_N;

  always_comb begin
    push_entry.data        = data_byte;
    push_entry.last        = last_byte;
    push_entry.short_frame = (pos <= cap_lo);
    if (pos == cap_lo) begin
      push_entry.kind = bsc_pkg::KIND_CAP;
    end else if (pos >= cap_lo + ELEM_OFS) begin
      push_entry.kind = bsc_pkg::KIND_ELEM;
    end else begin
      push_entry.kind = bsc_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      order_seen <= 1'b0;
    end else if (push) begin
      if (last_byte) begin
        pos        <= '0;
        order_seen <= 1'b0;
      end else begin
        order_seen <= order_next;
        if (pos < POS_MAX) begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsc_queue.sv */
// short byte queue between front and back of the classifier
// uses bsc_pkg for the entry type and depth
`default_nettype none

module bsc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bsc_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output bsc_pkg::entry_t       head,
  output bsc_pkg::q_stat_t      q_stat
);

  localparam int CW = bsc_pkg::Q_AW + 1;

  bsc_pkg::entry_t          slots [bsc_pkg::Q_DEPTH];
  logic [bsc_pkg::Q_AW-1:0] wr_ptr;
  logic [bsc_pkg::Q_AW-1:0] rd_ptr;
  logic [CW-1:0]            count;

  assign q_stat.full  = (count == CW'(bsc_pkg::Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bsc_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bsc_pkg::Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsc_back.sv */
// back of the classifier: walks information elements, checks akm suites,
// registers one result per frame; uses bsc_pkg
`default_nettype none

module bsc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bsc_pkg::q_stat_t q_stat,
  input  wire bsc_pkg::entry_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            security_class,
  output logic                  rsn_found,
  output logic                  wpa_found
);

  logic              privacy, privacy_next;
  logic [7:0]        elem_id, elem_id_next;
  logic [7:0]        remaining, remaining_next;
  logic [7:0]        idx, idx_next;
  bsc_pkg::phase_t   phase, phase_next;
  logic [15:0]       cnt, cnt_next;
  logic [1:0]        sbi, sbi_next;
  logic              oui, oui_next;
  bsc_pkg::cls_t     rsn_cls, rsn_cls_next;
  bsc_pkg::cls_t     wpa_cls, wpa_cls_next;
  logic              rsn_seen, rsn_seen_next;
  logic              wpa_seen, wpa_seen_next;
  bsc_pkg::cls_t     cls_next;

  logic [7:0]        b;
  logic              is_rsn;
  logic [7:0]        base;
  logic [15:0]       cnt_dec;
  logic [15:0]       cnt_hi;
  logic              stop;

  assign pop = !q_stat.empty && (!head.last || !out_valid || out_ready);

  assign b       = head.data;
  assign is_rsn  = (elem_id == bsc_pkg::ID_RSN);
  assign base    = is_rsn ? bsc_pkg::RSN_COUNT_AT : bsc_pkg::WPA_COUNT_AT;
  assign cnt_dec = cnt - 16'd1;
  assign cnt_hi  = cnt | {b, 8'h00};

  always_comb begin
    privacy_next   = privacy;
    elem_id_next   = elem_id;
    remaining_next = remaining;
    idx_next       = idx;
    phase_next     = phase;
    cnt_next       = cnt;
    sbi_next       = sbi;
    oui_next       = oui;
    rsn_cls_next   = rsn_cls;
    wpa_cls_next   = wpa_cls;
    rsn_seen_next  = rsn_seen;
    wpa_seen_next  = wpa_seen;
    stop           = 1'b0;

    if (head.kind == bsc_pkg::KIND_CAP) begin
      privacy_next = ((b & bsc_pkg::PRIVACY_MASK) != 8'h00);
    end else if (head.kind == bsc_pkg::KIND_ELEM) begin
      case (phase)
        bsc_pkg::PH_ID: begin
          elem_id_next = b;
          if (b == bsc_pkg::ID_RSN) begin
            rsn_seen_next = 1'b1;
            rsn_cls_next  = bsc_pkg::CLS_UNKNOWN;
          end
          phase_next = bsc_pkg::PH_LEN;
        end
        bsc_pkg::PH_LEN: begin
          remaining_next = b;
          idx_next       = 8'd0;
          sbi_next       = 2'd0;
          cnt_next       = 16'd0;
          oui_next       = 1'b0;
          if (b == 8'd0) begin
            phase_next = bsc_pkg::PH_ID;
          end else if (is_rsn || elem_id == bsc_pkg::ID_VENDOR) begin
            phase_next = bsc_pkg::PH_FIX;
          end else begin
            phase_next = bsc_pkg::PH_SKIP;
          end
        end
        default: begin
          // element body byte
          case (phase)
            bsc_pkg::PH_FIX: begin
              if (!is_rsn && idx < bsc_pkg::WPA_HDR_LEN) begin
                if (b != bsc_pkg::wpa_hdr_byte(idx[1:0])) begin
                  phase_next = bsc_pkg::PH_SKIP;
                end else if (idx == 8'd3) begin
                  wpa_seen_next = 1'b1;
                  wpa_cls_next  = bsc_pkg::CLS_UNKNOWN;
                end
              end else if (idx == base) begin
                cnt_next = {8'h00, b};
              end else if (idx == base + 8'd1) begin
                cnt_next   = cnt_hi;
                sbi_next   = 2'd0;
                phase_next = (cnt_hi != 16'd0) ? bsc_pkg::PH_PAIR : bsc_pkg::PH_AKMCNT;
              end
            end
            bsc_pkg::PH_PAIR: begin
              if (sbi == 2'd3) begin
                sbi_next = 2'd0;
                cnt_next = cnt_dec;
                if (cnt_dec == 16'd0) begin
                  phase_next = bsc_pkg::PH_AKMCNT;
                end
              end else begin
                sbi_next = sbi + 2'd1;
              end
            end
            bsc_pkg::PH_AKMCNT: begin
              if (sbi == 2'd0) begin
                cnt_next = {8'h00, b};
                sbi_next = 2'd1;
              end else begin
                cnt_next   = cnt_hi;
                sbi_next   = 2'd0;
                phase_next = (cnt_hi != 16'd0) ? bsc_pkg::PH_AKM : bsc_pkg::PH_SKIP;
              end
            end
            bsc_pkg::PH_AKM: begin
              case (sbi)
                2'd0: begin
                  oui_next = (b == 8'h00);
                  sbi_next = 2'd1;
                end
                2'd1: begin
                  oui_next = oui && (b == (is_rsn ? bsc_pkg::RSN_OUI_1 : bsc_pkg::WPA_OUI_1));
                  sbi_next = 2'd2;
                end
                2'd2: begin
                  oui_next = oui && (b == (is_rsn ? bsc_pkg::RSN_OUI_2 : bsc_pkg::WPA_OUI_2));
                  sbi_next = 2'd3;
                end
                default: begin
                  // suite type byte
                  if (oui && is_rsn) begin
                    case (b)
                      bsc_pkg::AKM_8021X: begin
                        if (rsn_cls == bsc_pkg::CLS_WPA3_ENT) begin
                          rsn_cls_next = bsc_pkg::CLS_ENT_TRANS;
                          stop         = 1'b1;
                        end else begin
                          rsn_cls_next = bsc_pkg::CLS_WPA2_ENT;
                        end
                      end
                      bsc_pkg::AKM_PSK: begin
                        if (rsn_cls == bsc_pkg::CLS_WPA3_SAE) begin
                          rsn_cls_next = bsc_pkg::CLS_PSK_TRANS;
                          stop         = 1'b1;
                        end else begin
                          rsn_cls_next = bsc_pkg::CLS_WPA2_PSK;
                        end
                      end
                      bsc_pkg::AKM_8021X_SHA256: begin
                        if (rsn_cls == bsc_pkg::CLS_WPA2_ENT) begin
                          rsn_cls_next = bsc_pkg::CLS_ENT_TRANS;
                          stop         = 1'b1;
                        end else begin
                          rsn_cls_next = bsc_pkg::CLS_WPA3_ENT;
                        end
                      end
                      bsc_pkg::AKM_SAE: begin
                        if (rsn_cls == bsc_pkg::CLS_WPA2_PSK) begin
                          rsn_cls_next = bsc_pkg::CLS_PSK_TRANS;
                          stop         = 1'b1;
                        end else begin
                          rsn_cls_next = bsc_pkg::CLS_WPA3_SAE;
                        end
                      end
                      default: begin
                      end
                    endcase
                  end else if (oui) begin
                    if (b == bsc_pkg::AKM_8021X) begin
                      wpa_cls_next = bsc_pkg::CLS_WPA_ENT;
                      stop         = 1'b1;
                    end else if (b == bsc_pkg::AKM_PSK) begin
                      wpa_cls_next = bsc_pkg::CLS_WPA_PSK;
                      stop         = 1'b1;
                    end
                  end
                  sbi_next = 2'd0;
                  cnt_next = cnt_dec;
                  if (stop || cnt_dec == 16'd0) begin
                    phase_next = bsc_pkg::PH_SKIP;
                  end
                end
              endcase
            end
            default: begin
            end
          endcase
          idx_next       = idx + 8'd1;
          remaining_next = remaining - 8'd1;
          if (remaining == 8'd1) begin
            phase_next = bsc_pkg::PH_ID;
          end
        end
      endcase
    end

    // class at end of frame, from the state this byte leaves
    if (head.short_frame) begin
      cls_next = bsc_pkg::CLS_UNKNOWN;
    end else if (!privacy_next) begin
      cls_next = bsc_pkg::CLS_OPEN;
    end else if (phase_next != bsc_pkg::PH_ID) begin
      cls_next = bsc_pkg::CLS_UNKNOWN;
    end else if (!rsn_seen_next && !wpa_seen_next) begin
      cls_next = bsc_pkg::CLS_WEP;
    end else if (wpa_seen_next) begin
      cls_next = wpa_cls_next;
    end else begin
      cls_next = rsn_cls_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && head.last)) begin
      privacy   <= 1'b0;
      elem_id   <= 8'd0;
      remaining <= 8'd0;
      idx       <= 8'd0;
      phase     <= bsc_pkg::PH_ID;
      cnt       <= 16'd0;
      sbi       <= 2'd0;
      oui       <= 1'b0;
      rsn_cls   <= bsc_pkg::CLS_UNKNOWN;
      wpa_cls   <= bsc_pkg::CLS_UNKNOWN;
      rsn_seen  <= 1'b0;
      wpa_seen  <= 1'b0;
    end else if (pop) begin
      privacy   <= privacy_next;
      elem_id   <= elem_id_next;
      remaining <= remaining_next;
      idx       <= idx_next;
      phase     <= phase_next;
      cnt       <= cnt_next;
      sbi       <= sbi_next;
      oui       <= oui_next;
      rsn_cls   <= rsn_cls_next;
      wpa_cls   <= wpa_cls_next;
      rsn_seen  <= rsn_seen_next;
      wpa_seen  <= wpa_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      security_class <= cls_next;
      rsn_found      <= rsn_seen_next;
      wpa_found      <= wpa_seen_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/beacon_security_classifier_unit.sv */
// the last byte passes through the byte queue and is popped by the back, which registers the result
// throughput: one frame byte per cycle while the queue is not full; a stalled result holds only the next last byte
// a four-entry byte queue lets the front keep taking bytes while the back waits
// reset: synchronous active-high rst clears position, parser state, queue and result valid
// no clearing pass; the block is ready for bytes once reset is released
`default_nettype none

module beacon_security_classifier_unit #(
  parameter int MAX_FRAME_BYTES = bsc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      security_class,
  output logic            rsn_found,
  output logic            wpa_found
);

  // front to queue
  logic             push;
  bsc_pkg::entry_t  push_entry;
  // queue to back
  logic             pop;
  bsc_pkg::entry_t  head;
  bsc_pkg::q_stat_t q_stat;

  // front: byte position, order bit, role of each byte (capability, element, skipped)
  bsc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue: decouples the byte transfer from the element walker
  bsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // back: element walker, akm checks, result register
  bsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .security_class (security_class),
    .rsn_found      (rsn_found),
    .wpa_found      (wpa_found)
  );

`ifndef SYNTHESIS
  // queue cannot be full and empty at once
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  // front stalls only on a full queue
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    in_ready == !q_stat.full)
    else $error("in_ready disagrees with queue fill");

  // class stays in range
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (security_class <= bsc_pkg::CLS_UNKNOWN))
    else $error("security class out of range");

  // without any rsn or wpa element only open, wep or unknown can result
  a_no_elem_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsn_found && !wpa_found) |->
      (security_class == bsc_pkg::CLS_OPEN || security_class == bsc_pkg::CLS_WEP ||
       security_class == bsc_pkg::CLS_UNKNOWN))
    else $error("protected class without security element");
`endif

endmodule

`default_nettype wire
